[sv/qrs_pkg.sv]
package qrs_pkg;
	localparam int CW = 32;
	localparam int FB = 16;
	// discriminant scaled by 2^(2F): up to 2*CW+3+2*FB bits
	localparam int DW = 2 * CW + 3 + 2 * FB;
	localparam int RW = (DW + 1) / 2 + 1;     // sqrt width
	localparam int NW = CW + FB + 2 + 1;      // numerator width
	localparam int QB = NW;                   // quotient bits
	localparam int XW = 3 * CW + 2 * FB + 4;  // residual width

	localparam logic [1:0] ST_TWO  = 2'd0;
	localparam logic [1:0] ST_REP  = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_AZ   = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] coeff_a;
		logic signed [CW-1:0] coeff_b;
		logic signed [CW-1:0] coeff_c;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic signed [CW-1:0] root_plus;
		logic signed [CW-1:0] root_minus;
		logic                 plus_exact;
		logic                 minus_exact;
		logic                 overflow;
	} out_item_t;

	// data handed down the chain
	typedef struct packed {
		logic                 vld;
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		logic [1:0]           status;
		logic [DW-1:0]        rad;   // remaining radicand
		logic [RW-1:0]        root;
		logic [NW-1:0]        nump;  // |numerators|
		logic [NW-1:0]        numm;
		logic                 negp;
		logic                 negm;
		logic [NW:0]          remp;
		logic [NW:0]          remm;
		logic [QB-1:0]        qp;
		logic [QB-1:0]        qm;
	} cell_t;
endpackage

[sv/qrs_sqrt_cell.sv]
// one restoring square-root digit
module qrs_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  qrs_pkg::cell_t d,
	output qrs_pkg::cell_t q
);
	import qrs_pkg::*;
	logic [DW+1:0] trial;
	logic [DW+1:0] remw;
	cell_t nx;

	always_comb begin
		nx = d;
		trial = ({{(DW+2-RW){1'b0}}, d.root} << (BIT + 1))
			| ({{(DW+1){1'b0}}, 1'b1} << (2 * BIT));
		remw = {2'b00, d.rad};
		if (remw >= trial) begin
			nx.rad = DW'(remw - trial);
			nx.root = d.root | (RW'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end
endmodule

[sv/qrs_div_cell.sv]
// one restoring-division bit for both roots, divisor |2a|
module qrs_div_cell #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  qrs_pkg::cell_t d,
	output qrs_pkg::cell_t q
);
	import qrs_pkg::*;
	logic [CW:0] am;
	logic [NW:0] dv;
	logic [NW:0] rp;
	logic [NW:0] rm;
	cell_t nx;

	always_comb begin
		nx = d;
		am = {d.a[CW-1], d.a};
		if (d.a[CW-1])
			am = -am;
		dv = {{(NW-CW-1){1'b0}}, am, 1'b0};
		rp = {d.remp[NW-1:0], d.nump[BIT]};
		rm = {d.remm[NW-1:0], d.numm[BIT]};
		nx.remp = rp;
		nx.remm = rm;
		if (rp >= dv) begin
			nx.remp = rp - dv;
			nx.qp[BIT] = 1'b1;
		end
		if (rm >= dv) begin
			nx.remm = rm - dv;
			nx.qm[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end
endmodule

[sv/qrs_finish.sv]
// rounding, saturation and residual check, four stages
module qrs_finish (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  qrs_pkg::cell_t  d,
	output logic            vld,
	output qrs_pkg::out_item_t item
);
	import qrs_pkg::*;
	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	function automatic logic [CW:0] rnd_sat(input logic [QB-1:0] qv, input logic [NW:0] rv,
		input logic [NW:0] dv, input logic neg);
		logic [QB:0] m;
		logic signed [QB+1:0] s;
		begin
			m = {1'b0, qv} + {{QB{1'b0}}, ((rv << 1) >= dv)};
			s = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
			if (s > $signed({{(QB+2-CW){1'b0}}, MAXV}))
				rnd_sat = {1'b1, MAXV};
			else if (s < $signed({{(QB+2-CW){1'b1}}, MINV}))
				rnd_sat = {1'b1, MINV};
			else
				rnd_sat = {1'b0, s[CW-1:0]};
		end
	endfunction

	logic [CW:0] am;
	logic [NW:0] dv;
	logic [CW:0] xp, xm;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [CW-1:0] a_s1, b_s1, c_s1, xp_s1, xm_s1;
	logic [1:0] st_s1, st_s2, st_s3, st_s4;
	logic ov_s1, ov_s2, ov_s3, ov_s4;
	logic signed [CW-1:0] xp_s2, xm_s2, xp_s3, xm_s3, xp_s4, xm_s4;
	logic signed [2*CW-1:0] axp_s2, axm_s2, bxp_s2, bxm_s2;
	logic signed [CW-1:0] c_s2, c_s3;
	// a*x*x as partial products of the upper and lower 32-bit halves of a*x
	logic signed [2*CW-1:0] hp_s3, hm_s3, bxp_s3, bxm_s3;
	logic signed [2*CW:0] lp_s3, lm_s3;
	logic signed [XW-1:0] resp, resm;
	logic ep_s4, em_s4;

	always_comb begin
		am = {d.a[CW-1], d.a};
		if (d.a[CW-1])
			am = -am;
		dv = {{(NW-CW-1){1'b0}}, am, 1'b0};
	end
	assign xp = rnd_sat(d.qp, d.remp, dv, d.negp);
	assign xm = rnd_sat(d.qm, d.remm, dv, d.negm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= d.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		resp = (XW'(hp_s3) <<< CW) + XW'(lp_s3) + (XW'(bxp_s3) <<< FB)
			+ (XW'(c_s3) <<< (2 * FB));
		resm = (XW'(hm_s3) <<< CW) + XW'(lm_s3) + (XW'(bxm_s3) <<< FB)
			+ (XW'(c_s3) <<< (2 * FB));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= d.a;
			b_s1 <= d.b;
			c_s1 <= d.c;
			st_s1 <= d.status;
			xp_s1 <= xp[CW-1:0];
			xm_s1 <= xm[CW-1:0];
			ov_s1 <= xp[CW] | xm[CW];
			axp_s2 <= a_s1 * xp_s1;
			axm_s2 <= a_s1 * xm_s1;
			bxp_s2 <= b_s1 * xp_s1;
			bxm_s2 <= b_s1 * xm_s1;
			c_s2 <= c_s1;
			xp_s2 <= xp_s1;
			xm_s2 <= xm_s1;
			st_s2 <= st_s1;
			ov_s2 <= ov_s1;
			hp_s3 <= $signed(axp_s2[2*CW-1:CW]) * xp_s2;
			hm_s3 <= $signed(axm_s2[2*CW-1:CW]) * xm_s2;
			lp_s3 <= $signed({1'b0, axp_s2[CW-1:0]}) * xp_s2;
			lm_s3 <= $signed({1'b0, axm_s2[CW-1:0]}) * xm_s2;
			bxp_s3 <= bxp_s2;
			bxm_s3 <= bxm_s2;
			c_s3 <= c_s2;
			xp_s3 <= xp_s2;
			xm_s3 <= xm_s2;
			st_s3 <= st_s2;
			ov_s3 <= ov_s2;
			xp_s4 <= xp_s3;
			xm_s4 <= xm_s3;
			st_s4 <= st_s3;
			ov_s4 <= ov_s3;
			ep_s4 <= (resp == '0);
			em_s4 <= (resm == '0);
		end
	end

	assign vld = v_s4;
	always_comb begin
		item = '0;
		item.status = st_s4;
		if (st_s4 == ST_TWO || st_s4 == ST_REP) begin
			item.root_plus = xp_s4;
			item.root_minus = xm_s4;
			item.plus_exact = ep_s4;
			item.minus_exact = em_s4;
			item.overflow = ov_s4;
		end
	end
endmodule

[sv/quadratic_root_solver_core.sv]
// Real roots of a*x*x + b*x + c in signed Q16.16.
// Input channel in_valid/in_stall/in_data carries one coefficient set per item;
// output channel out_valid/out_stall/out_data carries status, both roots, residual
// exact flags and an overflow flag, one result item per input item.
// Items are accepted one per cycle while in_stall is low; the cell chain holds
// 1 entry stage, RW square-root digit cells, 1 numerator stage, QB division
// cells and 4 finishing stages.
// Throughput is one item per clock while the chain is not frozen; each cell
// resolves one root bit or one quotient bit for both roots.
// The whole chain advances together; when the output register holds an item
// and out_stall is high the chain freezes and in_stall is raised, so nothing
// is lost or repeated. A free slot lets the chain move even under out_stall.
// Reset clears all valid bits of the chain; no item is in flight afterwards.
module quadratic_root_solver_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  qrs_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output qrs_pkg::out_item_t  out_data
);
	import qrs_pkg::*;
	localparam int NC = RW + QB;

	cell_t ch [0:NC+1];
	cell_t e;
	cell_t nm;
	logic en;
	logic fvld;
	out_item_t fitem;
	logic signed [2*CW-1:0] bb, ac;
	logic signed [2*CW+3:0] disc;
	logic signed [NW-1:0] nbp, nbm;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		e = '0;
		e.vld = in_valid;
		e.a = in_data.coeff_a;
		e.b = in_data.coeff_b;
		e.c = in_data.coeff_c;
		bb = in_data.coeff_b * in_data.coeff_b;
		ac = in_data.coeff_a * in_data.coeff_c;
		disc = (2*CW+4)'(bb) - ((2*CW+4)'(ac) <<< 2);
		if (in_data.coeff_a == '0) e.status = ST_AZ;
		else if (disc < 0) e.status = ST_NONE;
		else if (disc == 0) e.status = ST_REP;
		else e.status = ST_TWO;
		e.rad = (disc < 0) ? '0 : DW'(disc) << (2 * FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch[0] <= '0;
		end else if (en) begin
			ch[0] <= e;
		end
	end

	genvar g;
	generate
		for (g = 0; g < RW; g++) begin : g_sq
			qrs_sqrt_cell #(.BIT(RW - 1 - g)) u_c (
				.clk(clk), .arst_n(arst_n), .en(en), .d(ch[g]), .q(ch[g+1])
			);
		end
	endgenerate

	// numerators -b*2^F +/- root as magnitudes and signs
	always_comb begin
		nm = ch[RW];
		nbp = -($signed(NW'(ch[RW].b)) <<< FB) + $signed(NW'(ch[RW].root));
		nbm = -($signed(NW'(ch[RW].b)) <<< FB) - $signed(NW'(ch[RW].root));
		nm.negp = nbp[NW-1] ^ ch[RW].a[CW-1];
		nm.negm = nbm[NW-1] ^ ch[RW].a[CW-1];
		nm.nump = nbp[NW-1] ? NW'(-nbp) : NW'(nbp);
		nm.numm = nbm[NW-1] ? NW'(-nbm) : NW'(nbm);
		nm.remp = '0;
		nm.remm = '0;
		nm.qp = '0;
		nm.qm = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch[RW+1] <= '0;
		end else if (en) begin
			ch[RW+1] <= nm;
		end
	end

	generate
		for (g = 0; g < QB; g++) begin : g_dv
			qrs_div_cell #(.BIT(QB - 1 - g)) u_c (
				.clk(clk), .arst_n(arst_n), .en(en), .d(ch[RW+1+g]), .q(ch[RW+2+g])
			);
		end
	endgenerate

	qrs_finish u_fin (
		.clk(clk), .arst_n(arst_n), .en(en), .d(ch[NC+1]), .vld(fvld), .item(fitem)
	);

	assign out_valid = fvld;
	assign out_data = fitem;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("held result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("stall mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_TWO && out_data.status != ST_REP
		|-> out_data.root_plus == '0 && !out_data.overflow)
		else $error("roots on non-root status");
endmodule

[test/quadratic_root_solver_checker.sv]
`timescale 1ns / 1ps

module quadratic_root_solver_checker (
	input  logic               clk,
	input  logic               in_valid,
	input  logic               in_stall,
	input  qrs_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  qrs_pkg::out_item_t out_data,
	output int                 fail_count,
	output int                 pending
);
	import qrs_pkg::*;

	typedef logic signed [255:0] wide_t;

	out_item_t roots_q[$];

	function automatic wide_t floor_sqrt(wide_t n);
		wide_t r;
		wide_t t;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (wide_t'(1) << i);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// ties away from zero
	function automatic wide_t div_round(wide_t n, wide_t d);
		wide_t nm;
		wide_t dm;
		wide_t q;
		wide_t rm;
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		q = nm / dm;
		rm = nm % dm;
		if (2 * rm >= dm)
			q = q + 1;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic void one_root(input wide_t num, input wide_t a, input wide_t b,
			input wide_t c, inout logic ovf, output logic exact, output logic [CW-1:0] x_out);
		wide_t x;
		wide_t hi;
		wide_t lo;
		wide_t res;
		hi = (wide_t'(1) <<< (CW - 1)) - 1;
		lo = -(wide_t'(1) <<< (CW - 1));
		x = div_round(num, 2 * a);
		if (x > hi) begin
			x = hi;
			ovf = 1'b1;
		end
		if (x < lo) begin
			x = lo;
			ovf = 1'b1;
		end
		res = a * x * x + ((b * x) <<< FB) + (c <<< (2 * FB));
		exact = (res == 0);
		x_out = x[CW-1:0];
	endfunction

	function automatic out_item_t solve_roots(in_item_t it);
		out_item_t o;
		wide_t a;
		wide_t b;
		wide_t c;
		wide_t disc;
		wide_t sq;
		wide_t nb;
		logic ovf;
		o = '0;
		a = it.coeff_a;
		b = it.coeff_b;
		c = it.coeff_c;
		if (a == 0) begin
			o.status = ST_AZ;
			return o;
		end
		disc = b * b - 4 * a * c;
		if (disc < 0) begin
			o.status = ST_NONE;
			return o;
		end
		sq = floor_sqrt(disc <<< (2 * FB));
		nb = (-b) <<< FB;
		ovf = 1'b0;
		one_root(nb + sq, a, b, c, ovf, o.plus_exact, o.root_plus);
		one_root(nb - sq, a, b, c, ovf, o.minus_exact, o.root_minus);
		o.overflow = ovf;
		o.status = (disc == 0) ? ST_REP : ST_TWO;
		return o;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		out_item_t exp_r;
		if (in_valid && !in_stall)
			roots_q.push_back(solve_roots(in_data));
		if (out_valid && !out_stall) begin
			if (roots_q.size() == 0) begin
				$error("result item with nothing expected");
				fail_count++;
			end else begin
				exp_r = roots_q.pop_front();
				if (out_data.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, out_data.status);
					fail_count++;
				end
				if (out_data.root_plus !== exp_r.root_plus) begin
					$error("root_plus exp %h got %h", exp_r.root_plus, out_data.root_plus);
					fail_count++;
				end
				if (out_data.root_minus !== exp_r.root_minus) begin
					$error("root_minus exp %h got %h", exp_r.root_minus, out_data.root_minus);
					fail_count++;
				end
				if (out_data.plus_exact !== exp_r.plus_exact) begin
					$error("plus_exact exp %0d got %0d", exp_r.plus_exact, out_data.plus_exact);
					fail_count++;
				end
				if (out_data.minus_exact !== exp_r.minus_exact) begin
					$error("minus_exact exp %0d got %0d", exp_r.minus_exact,
						out_data.minus_exact);
					fail_count++;
				end
				if (out_data.overflow !== exp_r.overflow) begin
					$error("overflow exp %0d got %0d", exp_r.overflow, out_data.overflow);
					fail_count++;
				end
			end
		end
		pending <= roots_q.size();
	end
endmodule

[test/quadratic_root_solver_core_test.sv]
`timescale 1ns / 1ps

module quadratic_root_solver_core_test;
	import qrs_pkg::*;

	localparam int ONE = 65536;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	int        fail_count;
	int        pending;

	quadratic_root_solver_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	quadratic_root_solver_checker u_check (
		.clk       (clk),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5ms;
		$display("quadratic_root_solver_core_test NOT OK");
		$finish;
	end

	task automatic send_coeffs(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input bit may_idle);
		logic free;
		while (may_idle && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{coeff_a: a, coeff_b: b, coeff_c: c};
		do begin
			@(negedge clk);
			free = !in_stall;
			@(posedge clk);
		end while (!free);
	endtask

	task automatic send_random(input bit may_idle);
		int r1;
		int r2;
		int k;
		case ($urandom_range(4))
			0: send_coeffs($urandom, $urandom, $urandom, may_idle);
			1: send_coeffs($urandom_range(8) - 4, $urandom_range(8) - 4,
				$urandom_range(8) - 4, may_idle);
			2: send_coeffs(32'($urandom_range(2 * ONE) - ONE), 32'($urandom_range(8 * ONE)
				- 4 * ONE), 32'($urandom_range(8 * ONE) - 4 * ONE), may_idle);
			default: begin
				// integer roots so residuals come out exact
				r1 = $urandom_range(40) - 20;
				r2 = $urandom_range(40) - 20;
				k = $urandom_range(3) + 1;
				if ($urandom_range(1))
					k = -k;
				send_coeffs(k * ONE, -k * (r1 + r2) * ONE, k * r1 * r2 * ONE, may_idle);
			end
		endcase
	endtask

	// receiver: clean stretch, long hold-off, then random stalls
	initial begin
		int cyc;
		out_stall = 1'b0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc < 400)
				out_stall <= 1'b0;
			else if (cyc < 800)
				out_stall <= 1'b1;
			else
				out_stall <= ($urandom_range(99) < 30);
		end
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_coeffs(0, ONE, ONE, 1'b1);
		send_coeffs(0, 0, 0, 1'b1);
		send_coeffs(ONE, 0, ONE, 1'b1);
		send_coeffs(ONE, -2 * ONE, ONE, 1'b1);
		send_coeffs(ONE, 0, -4 * ONE, 1'b1);
		send_coeffs(-ONE, 3 * ONE, -2 * ONE, 1'b0);
		send_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_coeffs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_coeffs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_coeffs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_coeffs(1, 32'h7fff_ffff, 0, 1'b1);
		send_coeffs(-1, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
		send_coeffs(1, 0, 0, 1'b1);
		send_coeffs(ONE, ONE, 0, 1'b1);
		send_coeffs(2 * ONE, ONE, -ONE, 1'b1);
		send_coeffs(ONE, 0, -2 * ONE, 1'b1);
		send_coeffs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_coeffs(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1);

		// no idling on either side in this stretch
		for (int i = 0; i < 150; i++)
			send_random(1'b0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// the receiver hold-off lands in this stretch
		for (int i = 0; i < 280; i++)
			send_random(1'b1);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("quadratic_root_solver_core_test OK");
		else
			$display("quadratic_root_solver_core_test NOT OK");
		$finish;
	end
endmodule
